[rtl/core/bfsg_pkg.sv]
package bfsg_pkg;

  // number of startup stages that the stage event accepts
  localparam int STAGE_COUNT = 11;

  // event modes
  localparam logic [2:0] MODE_BOOT       = 3'd0;
  localparam logic [2:0] MODE_HEALTHY    = 3'd1;
  localparam logic [2:0] MODE_RETRY      = 3'd2;
  localparam logic [2:0] MODE_FORCE_ON   = 3'd3;
  localparam logic [2:0] MODE_FORCE_OFF  = 3'd4;
  localparam logic [2:0] MODE_STAGE      = 3'd5;
  localparam logic [2:0] MODE_DISP_BEGIN = 3'd6;
  localparam logic [2:0] MODE_DISP_DONE  = 3'd7;

  // reset classes
  localparam logic [1:0] CLS_CLEAN   = 2'd0;
  localparam logic [1:0] CLS_FAULT   = 2'd1;
  localparam logic [1:0] CLS_POWER   = 2'd2;
  localparam logic [1:0] CLS_UNKNOWN = 2'd3;

  // safe mode entry reasons
  localparam logic [1:0] ENTRY_NONE         = 2'd0;
  localparam logic [1:0] ENTRY_REPEATED     = 2'd1;
  localparam logic [1:0] ENTRY_RETRY_FAILED = 2'd2;
  localparam logic [1:0] ENTRY_FORCED       = 2'd3;

  // reset cause codes
  localparam logic [3:0] CAUSE_PANIC      = 4'd3;
  localparam logic [3:0] CAUSE_INT_WDT    = 4'd4;
  localparam logic [3:0] CAUSE_TASK_WDT   = 4'd5;
  localparam logic [3:0] CAUSE_WDT        = 4'd6;
  localparam logic [3:0] CAUSE_BROWNOUT   = 4'd8;
  localparam logic [3:0] CAUSE_GLITCH     = 4'd13;
  localparam logic [3:0] CAUSE_LOCKUP     = 4'd14;
  localparam logic [3:0] CAUSE_UNKNOWN    = 4'd15;

  // retained guard state
  typedef struct packed {
    logic [7:0] fault_count;
    logic [7:0] power_count;
    logic [3:0] current_stage;
    logic [3:0] reached_stage;
    logic       armed_flag;
    logic       retry_flag;
    logic       forced_flag;
    logic       in_safe_flag;
    logic       display_failed_flag;
  } guard_state_t;

  // one event request
  typedef struct packed {
    logic [2:0] mode;
    logic [3:0] reset_cause;
    logic [3:0] stage_code;
    logic       painted;
  } event_t;

  // one result
  typedef struct packed {
    logic       safe;
    logic [1:0] entry_reason;
    logic [1:0] cause_group;
    logic [7:0] fault_total;
    logic [7:0] power_total;
    logic [3:0] last_stage;
    logic       previous_safe;
    logic       display_allowed;
  } result_t;

  // map a reset cause onto its class
  function automatic logic [1:0] cause_class(input logic [3:0] cause);
    logic [1:0] cls;
    unique case (cause)
      CAUSE_PANIC, CAUSE_INT_WDT, CAUSE_TASK_WDT, CAUSE_WDT, CAUSE_LOCKUP: cls = CLS_FAULT;
      CAUSE_BROWNOUT, CAUSE_GLITCH: cls = CLS_POWER;
      CAUSE_UNKNOWN: cls = CLS_UNKNOWN;
      default: cls = CLS_CLEAN;
    endcase
    return cls;
  endfunction

  // saturating increment of an 8 bit counter
  function automatic logic [7:0] sat_inc(input logic [7:0] v);
    return (v == 8'hff) ? 8'hff : v + 8'd1;
  endfunction

endpackage

[rtl/core/bfsg_req_if.sv]
interface bfsg_req_if;
  logic       valid;
  logic       ready;
  logic [2:0] mode;
  logic [3:0] reset_cause;
  logic [3:0] stage_code;
  logic       painted;

  modport source (output valid, mode, reset_cause, stage_code, painted, input ready);
  modport sink (input valid, mode, reset_cause, stage_code, painted, output ready);
endinterface

[rtl/core/bfsg_res_if.sv]
interface bfsg_res_if;
  logic       valid;
  logic       ready;
  logic       safe;
  logic [1:0] entry_reason;
  logic [1:0] cause_group;
  logic [7:0] fault_total;
  logic [7:0] power_total;
  logic [3:0] last_stage;
  logic       previous_safe;
  logic       display_allowed;

  modport source (
    output valid, safe, entry_reason, cause_group, fault_total, power_total,
           last_stage, previous_safe, display_allowed,
    input  ready
  );
  modport sink (
    input  valid, safe, entry_reason, cause_group, fault_total, power_total,
           last_stage, previous_safe, display_allowed,
    output ready
  );
endinterface

[rtl/core/bfsg_step.sv]
module bfsg_step (
  input  bfsg_pkg::guard_state_t state,
  input  bfsg_pkg::event_t       evt,
  input  logic [7:0]             fault_limit,
  output bfsg_pkg::guard_state_t state_next,
  output bfsg_pkg::result_t      result
);
  import bfsg_pkg::*;

  logic [1:0] cls;
  logic       counted;
  logic [7:0] boot_faults;
  logic [7:0] boot_powers;
  logic [1:0] entry;
  logic       boot_safe;
  logic       stage_ok;

  // boot path: classify, count, decide
  always_comb begin
    cls         = cause_class(evt.reset_cause);
    counted     = 1'b0;
    boot_faults = state.fault_count;
    boot_powers = state.power_count;
    if (cls == CLS_POWER) begin
      boot_powers = sat_inc(state.power_count);
    end else if (state.armed_flag && (cls == CLS_FAULT || cls == CLS_UNKNOWN)) begin
      boot_faults = sat_inc(state.fault_count);
      counted     = 1'b1;
    end
    priority if (state.forced_flag) begin
      entry = ENTRY_FORCED;
    end else if (boot_faults >= fault_limit) begin
      entry = (state.retry_flag && counted) ? ENTRY_RETRY_FAILED : ENTRY_REPEATED;
    end else begin
      entry = ENTRY_NONE;
    end
    boot_safe = (entry != ENTRY_NONE);
  end

  assign stage_ok = {1'b0, evt.stage_code} < 5'(STAGE_COUNT);

  // state update per event
  always_comb begin
    state_next = state;
    unique case (evt.mode)
      MODE_BOOT: begin
        state_next.fault_count   = boot_faults;
        state_next.power_count   = boot_powers;
        state_next.reached_stage = state.current_stage;
        state_next.current_stage = 4'd0;
        state_next.in_safe_flag  = boot_safe;
        state_next.armed_flag    = !boot_safe;
        state_next.retry_flag    = !boot_safe && state.retry_flag;
      end
      MODE_HEALTHY: begin
        state_next.armed_flag  = 1'b0;
        state_next.retry_flag  = 1'b0;
        state_next.fault_count = 8'd0;
        state_next.power_count = 8'd0;
      end
      MODE_RETRY: begin
        state_next.forced_flag         = 1'b0;
        state_next.retry_flag          = 1'b1;
        state_next.armed_flag          = 1'b0;
        state_next.fault_count         = (fault_limit == 8'd0) ? 8'd0 : fault_limit - 8'd1;
        state_next.display_failed_flag = 1'b0;
      end
      MODE_FORCE_ON: begin
        state_next.forced_flag = 1'b1;
      end
      MODE_FORCE_OFF: begin
        state_next.forced_flag = 1'b0;
        state_next.fault_count = 8'd0;
        state_next.power_count = 8'd0;
        state_next.retry_flag  = 1'b0;
      end
      MODE_STAGE: begin
        if (stage_ok) begin
          state_next.current_stage = evt.stage_code;
        end
      end
      MODE_DISP_BEGIN: begin
        state_next.display_failed_flag = 1'b1;
      end
      MODE_DISP_DONE: begin
        if (evt.painted) begin
          state_next.display_failed_flag = 1'b0;
        end
      end
      default: begin
        state_next = state;
      end
    endcase
  end

  // result fields
  always_comb begin
    result.safe            = (evt.mode == MODE_BOOT) && boot_safe;
    result.entry_reason    = (evt.mode == MODE_BOOT) ? entry : ENTRY_NONE;
    result.cause_group     = (evt.mode == MODE_BOOT) ? cls : CLS_CLEAN;
    result.previous_safe   = (evt.mode == MODE_BOOT) && state.in_safe_flag;
    result.fault_total     = state_next.fault_count;
    result.power_total     = state_next.power_count;
    result.last_stage      = state_next.reached_stage;
    result.display_allowed = !state_next.display_failed_flag;
  end

endmodule

[rtl/core/boot_fault_safe_mode_guard.sv]
// Boot fault guard: one result per request, in order. A request is taken
// into an input register; from there the state update and the result are
// computed in a single pass and loaded into the result register once that
// register is empty or its result is taken, so one request per cycle is
// sustained while results are taken. While a result waits, the input
// register still takes one more request; after that the input stalls until
// the result is taken. fault_limit (reset 3) may only be written while no
// request is in flight.
module boot_fault_safe_mode_guard (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic [7:0]       cfg_wr_data,
  bfsg_req_if.sink         req,
  bfsg_res_if.source       res
);
  import bfsg_pkg::*;

  logic         in_valid;
  event_t       in_evt;
  logic         out_valid;
  result_t      out_res;
  logic [7:0]   fault_limit;
  guard_state_t state;
  guard_state_t state_next;
  result_t      step_res;
  logic         advance;

  // the result register frees when empty or taken
  assign advance   = in_valid && (!out_valid || res.ready);
  assign req.ready = !in_valid || advance;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      fault_limit <= 8'd3;
    end else if (cfg_wr_en) begin
      fault_limit <= cfg_wr_data;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (req.ready) begin
      in_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      in_evt <= '{mode: req.mode, reset_cause: req.reset_cause,
                  stage_code: req.stage_code, painted: req.painted};
    end
  end

  bfsg_step u_step (
    .state       (state),
    .evt         (in_evt),
    .fault_limit (fault_limit),
    .state_next  (state_next),
    .result      (step_res)
  );

  // retained state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= step_res;
    end
  end

  assign res.valid           = out_valid;
  assign res.safe            = out_res.safe;
  assign res.entry_reason    = out_res.entry_reason;
  assign res.cause_group     = out_res.cause_group;
  assign res.fault_total     = out_res.fault_total;
  assign res.power_total     = out_res.power_total;
  assign res.last_stage      = out_res.last_stage;
  assign res.previous_safe   = out_res.previous_safe;
  assign res.display_allowed = out_res.display_allowed;

endmodule

[rtl/core/bfsg_checker.sv]
module bfsg_checker (
  input logic       clk,
  input logic       rst,
  input logic       res_valid,
  input logic       res_ready,
  input logic       res_safe,
  input logic [1:0] res_entry_reason,
  input logic [7:0] res_fault_total
);
  import bfsg_pkg::*;

  // a stalled result stays offered
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result dropped while stalled");

  // nothing offered straight out of reset
  a_reset_empty: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !res_valid)
    else $error("result offered right after reset");

  // safe mode goes with a reason and only with one
  a_safe_reason: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res_safe == (res_entry_reason != ENTRY_NONE)))
    else $error("safe flag and entry reason disagree");

  // a failed retry has just counted a fault
  a_retry_counted: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_entry_reason == ENTRY_RETRY_FAILED |-> res_fault_total != 8'd0)
    else $error("failed retry with no fault counted");

endmodule

bind boot_fault_safe_mode_guard bfsg_checker u_bfsg_checker (
  .clk              (clk),
  .rst              (rst),
  .res_valid        (res.valid),
  .res_ready        (res.ready),
  .res_safe         (res.safe),
  .res_entry_reason (res.entry_reason),
  .res_fault_total  (res.fault_total)
);
